/* rtl/hqr_pkg.sv */
package hqr_pkg;

    localparam int MaxOrder = 8;
    localparam int FracBits = 16;
    localparam int ElemW    = 32;
    localparam int Depth    = 64;
    localparam int AddrW    = $clog2(Depth);
    localparam int OrderW   = 4;
    localparam int RotN     = MaxOrder - 1;
    localparam int KW       = $clog2(RotN);
    localparam int QW       = FracBits + 1;
    localparam int CsW      = FracBits + 2;
    localparam int NumW     = ElemW + FracBits + 1;
    localparam int MulW     = ElemW + 1;
    localparam int AccW     = 2 * ElemW + 1;
    localparam int SqW      = 2 * ElemW;
    localparam int DivCntW  = $clog2(QW + 1);

    typedef enum logic [2:0] {
        MUL_XX,
        MUL_YY,
        MUL_CX,
        MUL_SY,
        MUL_CY,
        MUL_SX
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        logic             mem_we;
        logic             mem_we_load;
        logic [AddrW-1:0] wr_addr;
        logic [AddrW-1:0] rd_addr;
        logic             ld_x;
        logic             ld_y;
        t_mul_sel         mul_sel;
        t_acc_op          acc_op;
        logic             sqrt_start;
        logic             div_start;
        logic             div_sel_y;
        logic             rot_wr;
        logic             rot_rd;
        logic [KW-1:0]    rot_k;
    } t_dp_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic norm_zero;
        logic div_done;
    } t_dp_stat;

endpackage

/* rtl/hessenberg_qr_givens_step_top.sv */
// One unshifted QR step (H -> RQ) on an upper Hessenberg matrix of order 2..8
// in signed Q16.16, by Givens rotations. Elements are loaded column-major, one
// per transfer (start high while busy low), and transfers may run back to
// back; the transfer with i_load_last set starts the work and busy rises.
// Per subdiagonal pair the block does two reads, the squares, a 32-pass
// square root and two 17-pass divisions, and it fetches the saved rotation
// again for its column pass. Each element pair rotation runs on the single
// shared multiplier and the memory's one read and one write port. The m*m
// results then leave one per cycle, column-major, each marked by
// o_result_strobe for one cycle; the receiver cannot stall them, so it must
// take every strobe. A zero-norm pair stops the work and all results carry
// o_zero_norm_error. The order register may be written only while
// busy is low.
module hessenberg_qr_givens_step_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cfg_we,
    input  logic [hqr_pkg::OrderW-1:0]         i_cfg_data,
    input  logic signed [hqr_pkg::ElemW-1:0]   i_element_value,
    input  logic                               i_load_last,
    output logic                               o_result_strobe,
    output logic signed [hqr_pkg::ElemW-1:0]   o_result_value,
    output logic                               o_result_last,
    output logic                               o_zero_norm_error
);
    import hqr_pkg::*;

    logic [OrderW-1:0] r_order;
    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic              w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= OrderW'(MaxOrder);
        end else if (i_cfg_we) begin
            r_order <= i_cfg_data;
        end
    end

    hqr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start && !w_busy),
        .i_load_last  (i_load_last),
        .i_order      (r_order),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_busy       (w_busy),
        .o_res_strobe (o_result_strobe),
        .o_res_last   (o_result_last),
        .o_err        (o_zero_norm_error)
    );

    hqr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_load_value (i_element_value),
        .o_stat       (w_stat),
        .o_rd_data    (o_result_value)
    );

    assign busy = w_busy;

endmodule

/* rtl/hqr_datapath.sv */
module hqr_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hqr_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [hqr_pkg::ElemW-1:0]     i_load_value,
    output hqr_pkg::t_dp_stat                    o_stat,
    output logic signed [hqr_pkg::ElemW-1:0]     o_rd_data
);
    import hqr_pkg::*;

    localparam logic signed [AccW-1:0] SatHi =
        {{(AccW-ElemW+1){1'b0}}, {(ElemW-1){1'b1}}};
    localparam logic signed [AccW-1:0] SatLo =
        {{(AccW-ElemW+1){1'b1}}, {(ElemW-1){1'b0}}};
    localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< (FracBits - 1);

    logic signed [ElemW-1:0] r_mem [Depth];
    logic signed [ElemW-1:0] r_rd_data;

    logic signed [ElemW-1:0] r_x, r_y;
    logic signed [CsW-1:0]   r_c, r_s;
    logic signed [CsW-1:0]   r_rot_c [RotN];
    logic signed [CsW-1:0]   r_rot_s [RotN];
    logic signed [AccW-1:0]  r_prod, r_acc;

    logic [SqW-1:0]   r_sq_v, r_sq_r, r_sq_bit;
    logic             r_sq_busy, r_sq_done;
    logic [ElemW-1:0] r_n;

    logic [ElemW-1:0]   r_dv_rem;
    logic [QW-1:0]      r_dv_low, r_dv_q;
    logic [DivCntW-1:0] r_dv_cnt;
    logic               r_dv_busy, r_dv_done, r_dv_neg, r_dv_to_s;

    logic [ElemW-1:0]        w_abs_x, w_abs_y, w_mag;
    logic signed [MulW-1:0]  w_op_a, w_op_b;
    logic signed [2*MulW-1:0] w_prod;
    logic signed [AccW-1:0]  w_round, w_shift;
    logic signed [ElemW-1:0] w_rescaled;
    logic [SqW-1:0]          w_sq_sum, w_sq_r_next;
    logic [NumW-1:0]         w_num;
    logic [ElemW:0]          w_trial;
    logic                    w_ge;
    logic [QW-1:0]           w_q_final;
    logic signed [CsW-1:0]   w_cs;

    assign w_abs_x = r_x[ElemW-1] ? ElemW'(-r_x) : ElemW'(r_x);
    assign w_abs_y = r_y[ElemW-1] ? ElemW'(-r_y) : ElemW'(r_y);

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_XX: begin
                w_op_a = signed'({1'b0, w_abs_x});
                w_op_b = signed'({1'b0, w_abs_x});
            end
            MUL_YY: begin
                w_op_a = signed'({1'b0, w_abs_y});
                w_op_b = signed'({1'b0, w_abs_y});
            end
            MUL_CX: begin
                w_op_a = MulW'(r_c);
                w_op_b = MulW'(r_x);
            end
            MUL_SY: begin
                w_op_a = MulW'(r_s);
                w_op_b = MulW'(r_y);
            end
            MUL_CY: begin
                w_op_a = MulW'(r_c);
                w_op_b = MulW'(r_y);
            end
            MUL_SX: begin
                w_op_a = MulW'(r_s);
                w_op_b = MulW'(r_x);
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_prod = w_op_a * w_op_b;

    // round to nearest, ties up, then saturate
    assign w_round = r_acc + RoundHalf;
    assign w_shift = w_round >>> FracBits;
    always_comb begin
        if (w_shift > SatHi) begin
            w_rescaled = SatHi[ElemW-1:0];
        end else if (w_shift < SatLo) begin
            w_rescaled = SatLo[ElemW-1:0];
        end else begin
            w_rescaled = w_shift[ElemW-1:0];
        end
    end

    assign w_sq_sum    = r_sq_r + r_sq_bit;
    assign w_sq_r_next = (r_sq_v >= w_sq_sum) ? ((r_sq_r >> 1) + r_sq_bit) : (r_sq_r >> 1);

    assign w_mag     = i_cmd.div_sel_y ? w_abs_y : w_abs_x;
    assign w_num     = (NumW'(w_mag) << FracBits) + NumW'(r_n >> 1);
    assign w_trial   = {r_dv_rem, r_dv_low[QW-1]};
    assign w_ge      = w_trial >= {1'b0, r_n};
    assign w_q_final = {r_dv_q[QW-2:0], w_ge};
    assign w_cs      = r_dv_neg ? -signed'(CsW'(w_q_final)) : signed'(CsW'(w_q_final));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.mem_we_load ? i_load_value : w_rescaled;
        end
        r_rd_data <= r_mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_x) begin
            r_x <= r_rd_data;
        end
        if (i_cmd.ld_y) begin
            r_y <= r_rd_data;
        end
        r_prod <= w_prod[AccW-1:0];
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            ACC_SUB:  r_acc <= r_acc - r_prod;
            default:  r_acc <= r_acc;
        endcase
        if (i_cmd.rot_wr) begin
            r_rot_c[i_cmd.rot_k] <= r_c;
            r_rot_s[i_cmd.rot_k] <= r_s;
        end
        if (i_cmd.rot_rd) begin
            r_c <= r_rot_c[i_cmd.rot_k];
            r_s <= r_rot_s[i_cmd.rot_k];
        end else if (r_dv_busy && r_dv_cnt == DivCntW'(1)) begin
            if (r_dv_to_s) begin
                r_s <= w_cs;
            end else begin
                r_c <= w_cs;
            end
        end
    end

    // integer square root, two radicand bits per pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_done <= 1'b0;
        end else begin
            r_sq_done <= 1'b0;
            if (i_cmd.sqrt_start) begin
                r_sq_v    <= r_acc[SqW-1:0];
                r_sq_r    <= '0;
                r_sq_bit  <= SqW'(1) << (SqW - 2);
                r_sq_busy <= 1'b1;
            end else if (r_sq_busy) begin
                if (r_sq_v >= w_sq_sum) begin
                    r_sq_v <= r_sq_v - w_sq_sum;
                end
                r_sq_r   <= w_sq_r_next;
                r_sq_bit <= r_sq_bit >> 2;
                if (r_sq_bit[0]) begin
                    r_sq_busy <= 1'b0;
                    r_sq_done <= 1'b1;
                    r_n       <= w_sq_r_next[ElemW-1:0];
                end
            end
        end
    end

    // restoring divider; quotient fits QW bits since |x| <= n
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_done <= 1'b0;
        end else begin
            r_dv_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_dv_rem  <= w_num[NumW-1:QW];
                r_dv_low  <= w_num[QW-1:0];
                r_dv_q    <= '0;
                r_dv_cnt  <= DivCntW'(QW);
                r_dv_neg  <= i_cmd.div_sel_y ? r_y[ElemW-1] : r_x[ElemW-1];
                r_dv_to_s <= i_cmd.div_sel_y;
                r_dv_busy <= 1'b1;
            end else if (r_dv_busy) begin
                r_dv_rem <= w_ge ? ElemW'(w_trial - {1'b0, r_n}) : w_trial[ElemW-1:0];
                r_dv_low <= r_dv_low << 1;
                r_dv_q   <= w_q_final;
                r_dv_cnt <= r_dv_cnt - DivCntW'(1);
                if (r_dv_cnt == DivCntW'(1)) begin
                    r_dv_busy <= 1'b0;
                    r_dv_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.sqrt_done = r_sq_done;
    assign o_stat.norm_zero = (r_n == '0);
    assign o_stat.div_done  = r_dv_done;
    assign o_rd_data        = r_rd_data;

endmodule

/* rtl/hqr_ctrl.sv */
module hqr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_load_last,
    input  logic [hqr_pkg::OrderW-1:0]  i_order,
    input  hqr_pkg::t_dp_stat           i_stat,
    output hqr_pkg::t_dp_cmd            o_cmd,
    output logic                        o_busy,
    output logic                        o_res_strobe,
    output logic                        o_res_last,
    output logic                        o_err
);
    import hqr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_P_RA, S_P_RB, S_P_LB, S_P_M1, S_P_M2, S_P_M3,
        S_P_SQ, S_P_SQW, S_P_DC, S_P_DS,
        S_R_RX, S_R_RY, S_R_LY, S_R_M2, S_R_M3, S_R_M4, S_R_M5, S_R_WY,
        S_C_ROT,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [AddrW-1:0]  r_load_cnt;
    logic [OrderW-1:0] r_m;
    logic [KW-1:0]     r_k, r_j;
    logic              r_col;
    logic [AddrW-1:0]  r_e;
    logic              r_strobe, r_last, r_err;

    logic [OrderW-1:0] w_m_clamped;
    logic [AddrW:0]    w_pair_a, w_row_x, w_col_x, w_x, w_y, w_total;
    logic              w_e_last, w_row_end, w_col_end, w_more_k;

    always_comb begin
        if (i_order < OrderW'(2)) begin
            w_m_clamped = OrderW'(2);
        end else if (i_order > OrderW'(MaxOrder)) begin
            w_m_clamped = OrderW'(MaxOrder);
        end else begin
            w_m_clamped = i_order;
        end
    end

    assign w_pair_a = (AddrW+1)'(r_k) * (AddrW+1)'(r_m) + (AddrW+1)'(r_k);
    assign w_row_x  = (AddrW+1)'(r_j) * (AddrW+1)'(r_m) + (AddrW+1)'(r_k);
    assign w_col_x  = (AddrW+1)'(r_k) * (AddrW+1)'(r_m) + (AddrW+1)'(r_j);
    assign w_x      = r_col ? w_col_x : w_row_x;
    assign w_y      = r_col ? (w_col_x + (AddrW+1)'(r_m)) : (w_row_x + (AddrW+1)'(1));
    assign w_total  = (AddrW+1)'(r_m) * (AddrW+1)'(r_m);
    assign w_e_last = ((AddrW+1)'(r_e) + (AddrW+1)'(1)) == w_total;
    assign w_row_end = (OrderW'(r_j) + OrderW'(1)) == r_m;
    assign w_col_end = (OrderW'(r_j) == OrderW'(r_k) + OrderW'(1));
    assign w_more_k  = (OrderW'(r_k) + OrderW'(2)) < r_m;

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_XX;
        o_cmd.acc_op  = ACC_HOLD;
        o_cmd.rot_k   = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.mem_we      = 1'b1;
                    o_cmd.mem_we_load = 1'b1;
                    o_cmd.wr_addr     = r_load_cnt;
                end
            end
            S_P_RA: o_cmd.rd_addr = w_pair_a[AddrW-1:0];
            S_P_RB: begin
                o_cmd.rd_addr = AddrW'(w_pair_a + (AddrW+1)'(1));
                o_cmd.ld_x    = 1'b1;
            end
            S_P_LB: o_cmd.ld_y = 1'b1;
            S_P_M1: o_cmd.mul_sel = MUL_XX;
            S_P_M2: begin
                o_cmd.mul_sel = MUL_YY;
                o_cmd.acc_op  = ACC_LOAD;
            end
            S_P_M3: o_cmd.acc_op = ACC_ADD;
            S_P_SQ: o_cmd.sqrt_start = 1'b1;
            S_P_SQW: begin
                if (i_stat.sqrt_done && !i_stat.norm_zero) begin
                    o_cmd.div_start = 1'b1;
                end
            end
            S_P_DC: begin
                if (i_stat.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel_y = 1'b1;
                end
            end
            S_P_DS: o_cmd.rot_wr = i_stat.div_done;
            S_R_RX: o_cmd.rd_addr = w_x[AddrW-1:0];
            S_R_RY: begin
                o_cmd.rd_addr = w_y[AddrW-1:0];
                o_cmd.ld_x    = 1'b1;
            end
            S_R_LY: begin
                o_cmd.ld_y    = 1'b1;
                o_cmd.mul_sel = MUL_CX;
            end
            S_R_M2: begin
                o_cmd.mul_sel = MUL_SY;
                o_cmd.acc_op  = ACC_LOAD;
            end
            S_R_M3: begin
                o_cmd.mul_sel = MUL_CY;
                o_cmd.acc_op  = ACC_ADD;
            end
            S_R_M4: begin
                o_cmd.mul_sel = MUL_SX;
                o_cmd.acc_op  = ACC_LOAD;
                o_cmd.mem_we  = 1'b1;
                o_cmd.wr_addr = w_x[AddrW-1:0];
            end
            S_R_M5: o_cmd.acc_op = ACC_SUB;
            S_R_WY: begin
                o_cmd.mem_we  = 1'b1;
                o_cmd.wr_addr = w_y[AddrW-1:0];
            end
            S_C_ROT: o_cmd.rot_rd = 1'b1;
            S_EMIT:  o_cmd.rd_addr = r_e;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_load_cnt <= '0;
            r_m        <= OrderW'(MaxOrder);
            r_k        <= '0;
            r_j        <= '0;
            r_col      <= 1'b0;
            r_e        <= '0;
            r_strobe   <= 1'b0;
            r_last     <= 1'b0;
            r_err      <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_load_last) begin
                            r_load_cnt <= '0;
                            r_m        <= w_m_clamped;
                            r_k        <= '0;
                            r_col      <= 1'b0;
                            r_err      <= 1'b0;
                            r_state    <= S_P_RA;
                        end else begin
                            r_load_cnt <= r_load_cnt + AddrW'(1);
                        end
                    end
                end
                S_P_RA:  r_state <= S_P_RB;
                S_P_RB:  r_state <= S_P_LB;
                S_P_LB:  r_state <= S_P_M1;
                S_P_M1:  r_state <= S_P_M2;
                S_P_M2:  r_state <= S_P_M3;
                S_P_M3:  r_state <= S_P_SQ;
                S_P_SQ:  r_state <= S_P_SQW;
                S_P_SQW: begin
                    if (i_stat.sqrt_done) begin
                        if (i_stat.norm_zero) begin
                            r_err   <= 1'b1;
                            r_e     <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_P_DC;
                        end
                    end
                end
                S_P_DC: begin
                    if (i_stat.div_done) begin
                        r_state <= S_P_DS;
                    end
                end
                S_P_DS: begin
                    if (i_stat.div_done) begin
                        r_j     <= r_k;
                        r_state <= S_R_RX;
                    end
                end
                S_R_RX: r_state <= S_R_RY;
                S_R_RY: r_state <= S_R_LY;
                S_R_LY: r_state <= S_R_M2;
                S_R_M2: r_state <= S_R_M3;
                S_R_M3: r_state <= S_R_M4;
                S_R_M4: r_state <= S_R_M5;
                S_R_M5: r_state <= S_R_WY;
                S_R_WY: begin
                    if (!r_col) begin
                        if (!w_row_end) begin
                            r_j     <= r_j + KW'(1);
                            r_state <= S_R_RX;
                        end else if (w_more_k) begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_P_RA;
                        end else begin
                            r_col   <= 1'b1;
                            r_k     <= '0;
                            r_state <= S_C_ROT;
                        end
                    end else begin
                        if (!w_col_end) begin
                            r_j     <= r_j + KW'(1);
                            r_state <= S_R_RX;
                        end else if (w_more_k) begin
                            r_k     <= r_k + KW'(1);
                            r_state <= S_C_ROT;
                        end else begin
                            r_e     <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_C_ROT: begin
                    r_j     <= '0;
                    r_state <= S_R_RX;
                end
                S_EMIT: begin
                    r_strobe <= 1'b1;
                    r_last   <= w_e_last;
                    r_e      <= r_e + AddrW'(1);
                    if (w_e_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_res_strobe = r_strobe;
    assign o_res_last   = r_last;
    assign o_err        = r_err;

endmodule

/* rtl/hqr_checker.sv */
module hqr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_load_last,
    input logic o_result_strobe,
    input logic o_result_last,
    input logic o_zero_norm_error
);

    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_last |-> o_result_strobe)
        else $error("result_last without strobe");

    a_last_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_load_last |=> busy)
        else $error("final load did not start work");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result outside a busy period");

    // busy drops already in the cycle of the final strobe
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_result_last |=> o_result_strobe)
        else $error("gap in result burst");

    a_err_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_result_last |=> $stable(o_zero_norm_error))
        else $error("error flag changed within a burst");

endmodule

bind hessenberg_qr_givens_step_top hqr_checker u_hqr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_load_last       (i_load_last),
    .o_result_strobe   (o_result_strobe),
    .o_result_last     (o_result_last),
    .o_zero_norm_error (o_zero_norm_error)
);
